FILE: design/sorted_key_table_node_assert.svh
// Assertion macros for the sorted key table node.
`ifndef SORTED_KEY_TABLE_NODE_ASSERT_SVH
`define SORTED_KEY_TABLE_NODE_ASSERT_SVH
// Implication checked every clock, off during reset.
`define SKT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/skt_pkg.sv
// Package: constants and types for the sorted key table node.
package skt_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned KeyW = 64;
  localparam int unsigned PayW = 64;
  localparam int unsigned LenW = 4;
  localparam int unsigned EntW = KeyW + PayW + LenW;

  localparam logic [2:0] FnInsert = 3'd0;
  localparam logic [2:0] FnRemove = 3'd1;
  localparam logic [2:0] FnExact  = 3'd2;
  localparam logic [2:0] FnFloor  = 3'd3;
  localparam logic [2:0] FnClear  = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StAbsent = 2'd1;
  localparam logic [1:0] StDup    = 2'd2;
  localparam logic [1:0] StFull   = 2'd3;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
    logic [LenW-1:0] len;
  } entry_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            has_payload;
    logic [PayW-1:0] payload;
    logic [LenW-1:0] payload_bytes;
    logic [6:0]      position;
    logic [6:0]      entries_now;
  } result_t;
endpackage

FILE: design/skt_ram.sv
// Entry memory: one write port, one registered read port.
module skt_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [skt_pkg::IdxW-1:0] waddr_i,
  input  skt_pkg::entry_t          wdata_i,
  input  logic [skt_pkg::IdxW-1:0] raddr_i,
  output skt_pkg::entry_t          rdata_o
);
  skt_pkg::entry_t mem [skt_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: design/sorted_key_table_node.sv
// Top level: sorted key table with sequenced binary search and entry shifting.
// Search reads and compares one probe at a time (up to 7 probes), then insert or
// remove shifts the entries from the position upward one slot at a time, read then write.
// One transaction at a time; s_axis_tready is low until the result is taken.
// Reset clears entry count, register and control; entry memory is not cleared.
module sorted_key_table_node (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // func, search_key, entry_payload, entry_payload_bytes
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,  // status, has_payload, result_payload,
                                      // result_payload_bytes, position, entries_now
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i
);
  localparam int unsigned IdxW = skt_pkg::IdxW;
  localparam int unsigned CntW = skt_pkg::CntW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;
  localparam logic [3:0] S_SCMP  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_FCMP  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PWAIT = 4'd7;
  localparam logic [3:0] S_SHRD  = 4'd8;
  localparam logic [3:0] S_SHWR  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q, state_d;
  logic uniq_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic [2:0] fn_q;
  logic [63:0] key_q, pay_q;
  logic [3:0] len_q;
  logic hit_q, hit_d;
  logic [CntW-1:0] pos_q, pos_d;
  skt_pkg::result_t res_q, res_d;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  skt_pkg::entry_t wdata, rdata;

  skt_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                 .raddr_i(raddr), .rdata_o(rdata));

  logic [CntW:0] midsum;
  logic [CntW-1:0] mid;
  assign midsum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = midsum[CntW:1];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {3'b000, res_q.entries_now, res_q.position, res_q.payload_bytes,
                         res_q.payload, res_q.has_payload, res_q.status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      uniq_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) uniq_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fn_q <= s_axis_tdata[2:0];
      key_q <= s_axis_tdata[66:3];
      pay_q <= s_axis_tdata[130:67];
      len_q <= s_axis_tdata[134:131];
    end
    lo_q <= lo_d;
    hi_q <= hi_d;
    ptr_q <= ptr_d;
    hit_q <= hit_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    lo_d = lo_q;
    hi_d = hi_q;
    ptr_d = ptr_q;
    hit_d = hit_q;
    pos_d = pos_q;
    res_d = res_q;
    we = 1'b0;
    waddr = ptr_q[IdxW-1:0];
    wdata = rdata;
    raddr = mid[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          lo_d = '0;
          hi_d = cnt_q;
          hit_d = 1'b0;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (fn_q > skt_pkg::FnFloor) begin
          if (fn_q == skt_pkg::FnClear) cnt_d = '0;
          res_d = '0;
          res_d.entries_now = 7'((fn_q == skt_pkg::FnClear) ? '0 : cnt_q);
          state_d = S_OUT;
        end else if (lo_q < hi_q) begin
          state_d = S_SCMP;
        end else begin
          pos_d = lo_q;
          state_d = S_DEC;
        end
      end
      S_SCMP: begin
        if (key_q < rdata.key) begin
          hi_d = mid;
          state_d = S_SRD;
        end else if (key_q > rdata.key) begin
          lo_d = mid + 1'b1;
          state_d = S_SRD;
        end else begin
          pos_d = mid;
          hit_d = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        res_d = '0;
        res_d.position = 7'(pos_q);
        res_d.entries_now = 7'(cnt_q);
        unique case (fn_q)
          skt_pkg::FnInsert: begin
            if (uniq_q && hit_q) begin
              res_d.status = skt_pkg::StDup;
              state_d = S_OUT;
            end else if (cnt_q == CntW'(skt_pkg::Capacity)) begin
              res_d.status = skt_pkg::StFull;
              state_d = S_OUT;
            end else begin
              ptr_d = cnt_q;
              res_d.entries_now = 7'(cnt_q + 1'b1);
              state_d = S_SHRD;
            end
          end
          skt_pkg::FnRemove: begin
            if (!hit_q) begin
              res_d.status = skt_pkg::StAbsent;
              state_d = S_OUT;
            end else begin
              ptr_d = pos_q;
              res_d.entries_now = 7'(cnt_q - 1'b1);
              state_d = S_SHRD;
            end
          end
          skt_pkg::FnExact: begin
            if (!hit_q) begin
              res_d.status = skt_pkg::StAbsent;
              state_d = S_OUT;
            end else begin
              ptr_d = pos_q;
              state_d = S_PRD;
            end
          end
          default: begin
            if (cnt_q == '0) begin
              res_d.status = skt_pkg::StAbsent;
              state_d = S_OUT;
            end else begin
              ptr_d = (pos_q >= cnt_q) ? cnt_q - 1'b1 : pos_q;
              state_d = S_FRD;
            end
          end
        endcase
      end
      S_FRD: begin
        raddr = ptr_q[IdxW-1:0];
        state_d = S_FCMP;
      end
      S_FCMP: begin
        if (rdata.key == key_q) begin
          res_d.status = skt_pkg::StOk;
          res_d.has_payload = 1'b1;
          res_d.payload = rdata.pay;
          res_d.payload_bytes = rdata.len;
          state_d = S_OUT;
        end else begin
          res_d.status = skt_pkg::StAbsent;
          if (rdata.key < key_q) begin
            res_d.has_payload = 1'b1;
            res_d.payload = rdata.pay;
            res_d.payload_bytes = rdata.len;
            state_d = S_OUT;
          end else if (ptr_q == '0) begin
            state_d = S_OUT;
          end else begin
            ptr_d = ptr_q - 1'b1;
            state_d = S_PRD;
          end
        end
      end
      S_PRD: begin
        raddr = ptr_q[IdxW-1:0];
        state_d = S_PWAIT;
      end
      S_PWAIT: begin
        res_d.has_payload = 1'b1;
        res_d.payload = rdata.pay;
        res_d.payload_bytes = rdata.len;
        state_d = S_OUT;
      end
      S_SHRD: begin
        // insert: move ptr-1 -> ptr down to pos; remove: move ptr+1 -> ptr
        if (fn_q == skt_pkg::FnInsert) begin
          raddr = IdxW'(ptr_q - 1'b1);
          if (ptr_q == pos_q) begin
            we = 1'b1;
            wdata.key = key_q;
            wdata.pay = pay_q;
            wdata.len = (len_q > 4'd8) ? 4'd8 : len_q;
            cnt_d = cnt_q + 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_SHWR;
          end
        end else begin
          raddr = IdxW'(ptr_q + 1'b1);
          if (ptr_q + 1'b1 >= cnt_q) begin
            cnt_d = cnt_q - 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_SHWR;
          end
        end
      end
      S_SHWR: begin
        we = 1'b1;
        ptr_d = (fn_q == skt_pkg::FnInsert) ? ptr_q - 1'b1 : ptr_q + 1'b1;
        state_d = S_SHRD;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

`include "sorted_key_table_node_assert.svh"
  `SKT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CntW'(skt_pkg::Capacity))
  `SKT_ASSERT_IMP(a_no_ready_busy, m_axis_tvalid, !s_axis_tready)
  `SKT_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `SKT_ASSERT_IMP(a_nopay_zero, m_axis_tvalid && !res_q.has_payload,
                  res_q.payload == '0 && res_q.payload_bytes == '0)
endmodule

FILE: test/sorted_key_table_node_test.sv
// Testbench for sorted_key_table_node: random and directed table operations.
`timescale 1ns / 100ps
module sorted_key_table_node_test;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [3:0]  bytes;
    logic [63:0] pay;
    logic [63:0] key;
    logic [2:0]  func;
  } table_op_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic         cfg_wdata_i = 1'b0;

  sorted_key_table_node u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // table model
  logic [63:0] mdl_key [skt_pkg::Capacity];
  logic [63:0] mdl_pay [skt_pkg::Capacity];
  logic [3:0]  mdl_len [skt_pkg::Capacity];
  int unsigned mdl_count = 0;
  logic        mdl_unique = 1'b0;

  table_op_t         pending_ops[$];
  skt_pkg::result_t  expected_results[$];
  logic [63:0]       key_pool[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          accepted = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_cnt = 0;

  function automatic skt_pkg::result_t table_apply(table_op_t op);
    skt_pkg::result_t r;
    int unsigned lo, hi, mid, pos, n, s, sel;
    bit          found;
    r = '0;
    sel = skt_pkg::Capacity + 1;
    if (op.func > skt_pkg::FnClear) begin
      r.entries_now = mdl_count[6:0];
      return r;
    end
    if (op.func == skt_pkg::FnClear) begin
      mdl_count = 0;
      return r;
    end
    lo = 0;
    hi = mdl_count;
    found = 1'b0;
    while (lo < hi && !found) begin
      mid = (lo + hi) >> 1;
      if (op.key < mdl_key[mid]) hi = mid;
      else if (op.key > mdl_key[mid]) lo = mid + 1;
      else begin
        lo = mid;
        found = 1'b1;
      end
    end
    pos = lo;
    n = mdl_count;
    r.position = pos[6:0];
    case (op.func)
      skt_pkg::FnInsert: begin
        if (mdl_unique && pos < n && mdl_key[pos] == op.key) r.status = skt_pkg::StDup;
        else if (n >= skt_pkg::Capacity) r.status = skt_pkg::StFull;
        else begin
          for (int i = n; i > pos; i--) begin
            mdl_key[i] = mdl_key[i-1];
            mdl_pay[i] = mdl_pay[i-1];
            mdl_len[i] = mdl_len[i-1];
          end
          mdl_key[pos] = op.key;
          mdl_pay[pos] = op.pay;
          mdl_len[pos] = (op.bytes > 8) ? 4'd8 : op.bytes;
          mdl_count = n + 1;
        end
      end
      skt_pkg::FnRemove: begin
        if (pos >= n || mdl_key[pos] != op.key) r.status = skt_pkg::StAbsent;
        else begin
          for (int i = pos; i < n - 1; i++) begin
            mdl_key[i] = mdl_key[i+1];
            mdl_pay[i] = mdl_pay[i+1];
            mdl_len[i] = mdl_len[i+1];
          end
          mdl_count = n - 1;
        end
      end
      skt_pkg::FnExact: begin
        if (pos < n && mdl_key[pos] == op.key) sel = pos;
        else r.status = skt_pkg::StAbsent;
      end
      default: begin
        r.status = skt_pkg::StAbsent;
        if (n != 0) begin
          s = (pos >= n) ? n - 1 : pos;
          if (mdl_key[s] == op.key) begin
            r.status = skt_pkg::StOk;
            sel = s;
          end else if (mdl_key[s] < op.key) sel = s;
          else if (s != 0) sel = s - 1;
        end
      end
    endcase
    if (sel < mdl_count) begin
      r.has_payload = 1'b1;
      r.payload = mdl_pay[sel];
      r.payload_bytes = mdl_len[sel];
    end
    r.entries_now = mdl_count[6:0];
    return r;
  endfunction

  // acceptance, prediction and result check
  always @(posedge clk_i) begin
    skt_pkg::result_t got, want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(table_apply(table_op_t'(s_axis_tdata[134:0])));
      accepted <= 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.status = m_axis_tdata[1:0];
      got.has_payload = m_axis_tdata[2];
      got.payload = m_axis_tdata[66:3];
      got.payload_bytes = m_axis_tdata[70:67];
      got.position = m_axis_tdata[77:71];
      got.entries_now = m_axis_tdata[84:78];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.has_payload !== want.has_payload
            || got.payload !== want.payload || got.payload_bytes !== want.payload_bytes
            || got.position !== want.position || got.entries_now !== want.entries_now) begin
          errors++;
          $display("%0t: mismatch exp st=%0d hp=%0d pay=%h len=%0d pos=%0d cnt=%0d",
                   $time, want.status, want.has_payload, want.payload,
                   want.payload_bytes, want.position, want.entries_now);
          $display("%0t:          act st=%0d hp=%0d pay=%h len=%0d pos=%0d cnt=%0d",
                   $time, got.status, got.has_payload, got.payload,
                   got.payload_bytes, got.position, got.entries_now);
        end
      end
    end
  end

  // sender
  always @(negedge clk_i) begin
    logic      nv;
    table_op_t op;
    nv = s_axis_tvalid;
    op = table_op_t'(s_axis_tdata[134:0]);
    if (!s_axis_tvalid || accepted) begin
      accepted <= 1'b0;
      nv = 1'b0;
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_ops.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(0, 8);
        else begin
          op = pending_ops.pop_front();
          nv = 1'b1;
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= {1'b0, op};
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  function automatic table_op_t make_op(logic [2:0] func, logic [63:0] key,
                                        logic [63:0] pay, logic [3:0] bytes);
    table_op_t op;
    op.func = func;
    op.key = key;
    op.pay = pay;
    op.bytes = bytes;
    return op;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) == 0) return rand_word();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic queue_random(int unsigned count, int unsigned ins_pct);
    int unsigned roll;
    logic [2:0]  func;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) func = skt_pkg::FnInsert;
      else if (roll < 97) func = 3'($urandom_range(skt_pkg::FnRemove, skt_pkg::FnFloor));
      else if (roll < 99) func = skt_pkg::FnClear;
      else func = 3'($urandom_range(5, 7));
      pending_ops.push_back(make_op(func, pick_key(), rand_word(), 4'($urandom_range(0, 15))));
    end
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_unique(logic value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_unique = value;
  endtask

  initial begin
    key_pool.push_back('0);
    key_pool.push_back('1);
    key_pool.push_back(64'h8000_0000_0000_0000);
    key_pool.push_back(64'h7fff_ffff_ffff_ffff);
    for (int i = 0; i < 80; i++) key_pool.push_back(rand_word());
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_unique(1'b0);
    pending_ops.push_back(make_op(skt_pkg::FnFloor, 64'd5, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnRemove, 64'd5, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnInsert, 64'd100, '1, 4'd8));
    pending_ops.push_back(make_op(skt_pkg::FnInsert, '0, 64'h0123_4567_89ab_cdef, 4'd15));
    pending_ops.push_back(make_op(skt_pkg::FnInsert, '1, '0, 4'd0));
    pending_ops.push_back(make_op(skt_pkg::FnInsert, 64'd100, 64'h5555, 4'd3));
    pending_ops.push_back(make_op(skt_pkg::FnExact, '0, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnExact, '1, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnExact, 64'd100, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnExact, 64'd50, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnFloor, 64'd50, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnFloor, 64'd100, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnFloor, '1, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnRemove, 64'd100, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnRemove, 64'd77, '0, '0));
    pending_ops.push_back(make_op(3'd5, '1, '1, 4'hf));
    pending_ops.push_back(make_op(3'd6, '0, '0, '0));
    pending_ops.push_back(make_op(3'd7, '1, '1, 4'hf));
    pending_ops.push_back(make_op(skt_pkg::FnClear, '0, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnFloor, '0, '0, '0));
    pending_ops.push_back(make_op(skt_pkg::FnInsert, 64'd9, 64'd1, 4'd1));
    drain();

    write_unique(1'b1);
    pending_ops.push_back(make_op(skt_pkg::FnInsert, 64'd9, 64'd2, 4'd2));
    hold_req = 1'b1;
    queue_random(420, 55);
    drain();

    write_unique(1'b0);
    pending_ops.push_back(make_op(skt_pkg::FnClear, '0, '0, '0));
    queue_random(450, 75);
    drain();

    write_unique(1'b1);
    queue_random(420, 45);
    drain();

    write_unique(1'b0);
    quiet = 1'b1;
    queue_random(440, 50);
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/skt_pkg.sv
design/skt_ram.sv
design/sorted_key_table_node.sv
test/sorted_key_table_node_test.sv
